FILE: design/ipra_pkg.sv
// Package for the I/O port range allocator: payload beats, codes, constants
// and the alignment rounding helper. No dependencies.
`timescale 1ns / 1ps

package ipra_pkg;

  localparam int unsigned TableEntriesDef = 32;

  localparam logic [17:0] SentinelPort = 18'h20000;
  localparam logic [18:0] SentinelLimit = 19'h20001;
  localparam logic [17:0] BaseReset = 18'h00400;
  localparam logic [17:0] VgaALo = 18'h002b0;
  localparam logic [18:0] VgaAEnd = 19'h002e0;  // last port 0x2df plus one
  localparam logic [17:0] VgaBLo = 18'h003c0;
  localparam logic [18:0] VgaBEnd = 19'h003db;  // last port 0x3da plus one

  typedef enum logic [1:0] {
    CMD_ALLOC_AT  = 2'd0,
    CMD_ALLOC_ANY = 2'd1,
    CMD_RELEASE   = 2'd2,
    CMD_CHECK     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CLASH    = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // Outcome of comparing the request against one table entry.
  typedef enum logic [1:0] {
    VD_CONT,
    VD_HIT,
    VD_CLASH,
    VD_MISS
  } verdict_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [17:0] port;
    logic [16:0] size;
    logic [4:0]  align_log2;
    logic [18:0] range_end;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [17:0] granted_port;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic    init_wr;
    logic    load;
    logic    step;
    logic    hit;
    logic    end_list;
    logic    sh_start;
    logic    sh_rd;
    logic    sh_wr;
    logic    put;
    logic    dec;
    logic    res_we;
    status_e res_status;
    logic    res_grant;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    verdict_e   verdict;
    logic       last;
    logic       empty;
    logic       vga;
    logic       full;
    logic       ins_shift;
    logic       rem_shift;
    logic       sh_last;
    logic [1:0] cmd;
  } stat_t;

  function automatic logic [31:0] round_up(logic [31:0] v, logic [31:0] m);
    logic [32:0] s;
    s = {1'b0, v} + {1'b0, m};
    return s[31:0] & ~m;
  endfunction

endpackage

FILE: design/io_port_range_allocator_unit.sv
// Top level of the I/O port range allocator: controller plus datapath.
// Depends on ipra_pkg, ipra_ctrl, ipra_dpath.
`timescale 1ns / 1ps

// Keeps a sorted table of allocated port ranges [start, limit) and serves
// four commands: alloc_at, alloc_any (first fit upward from search_base at a
// power-of-two alignment), release and check_range. A beat is taken at a
// clock edge with start high and busy low; its single result appears on
// rsp_o with done_o high for exactly one cycle and must be captured then,
// since the receiver cannot hold it off. busy stays high from the accepting
// edge until the cycle the result strobe shows. After reset busy is high for
// one cycle while the sentinel entry is written into the table RAM.
// The walk reads one entry a cycle through the table RAM's registered read
// port, and each shifted entry costs a read and a write state on that same
// RAM. The worst case is an insert or release at the front of a nearly full
// table. search_base is written through cfg_we_i / cfg_wdata_i; the user
// must write it only while idle, which the block itself does not enforce.

module io_port_range_allocator_unit import ipra_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [17:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o
);

  ctl_t  ctl;
  stat_t stat;

  // sequencing
  ipra_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  // table, compare and result registers
  ipra_dpath #(
    .TableEntries (TableEntries)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .rsp_o       (rsp_o)
  );

endmodule

FILE: design/ipra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ipra_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ipra_dpath.sv
// Allocator datapath: request and config registers, entry compare, counters,
// shift pointers and the range table RAM. Depends on ipra_pkg, ipra_ram.
`timescale 1ns / 1ps

module ipra_dpath import ipra_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [17:0] cfg_wdata_i,
  input  req_t        req_i,
  input  ctl_t        ctl_i,
  output stat_t       stat_o,
  output rsp_t        rsp_o
);

  localparam int unsigned IW = $clog2(TableEntries);
  localparam int unsigned CW = $clog2(TableEntries + 1);

  logic [17:0] base_q;
  req_t        req_q;
  logic [31:0] cand_q, cand_d, mask_q;
  logic [IW-1:0] idx_q, idx_d, src_q, raddr, waddr;
  logic [CW-1:0] cnt_q, pos_q;
  rsp_t        rsp_q;
  logic        we;
  logic [36:0] wdata, rdata;
  logic [17:0] ent_s;
  logic [18:0] ent_l;
  logic [18:0] at_end;
  logic [31:0] load_mask;
  logic [31:0] mx;
  logic        any_gt;
  logic [17:0] any_diff;
  logic        is_rel;
  logic [17:0] new_s;
  logic [18:0] new_l;
  logic [18:0] any_lim;
  logic [17:0] grant_val;
  verdict_e    verdict;

  assign ent_s  = rdata[36:19];
  assign ent_l  = rdata[18:0];
  assign at_end = {1'b0, req_q.port} + {2'b0, req_q.size};
  assign is_rel = (req_q.command == CMD_RELEASE);

  assign load_mask = (32'd1 << req_i.align_log2) - 32'd1;
  assign mx        = (cand_q > {13'b0, ent_l}) ? cand_q : {13'b0, ent_l};

  always_comb begin
    cand_d = cand_q;
    if (ctl_i.load) begin
      cand_d = round_up({14'b0, base_q}, load_mask);
    end else if (ctl_i.step) begin
      cand_d = round_up(mx, mask_q);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (ctl_i.load) begin
      idx_d = '0;
    end else if (ctl_i.step) begin
      idx_d = idx_q + IW'(1);
    end
  end

  // per-entry compare
  assign any_gt   = {14'b0, ent_s} > cand_q;
  assign any_diff = ent_s - cand_q[17:0];

  always_comb begin
    verdict = VD_CONT;
    case (req_q.command)
      CMD_ALLOC_AT: begin
        if (ent_l <= {1'b0, req_q.port}) begin
          verdict = VD_CONT;
        end else if ({1'b0, ent_s} >= at_end) begin
          verdict = VD_HIT;
        end else begin
          verdict = VD_CLASH;
        end
      end
      CMD_ALLOC_ANY: begin
        if (any_gt && ({1'b0, any_diff} > {2'b0, req_q.size})) begin
          verdict = VD_HIT;
        end
      end
      CMD_RELEASE: begin
        if (ent_s == req_q.port) begin
          verdict = VD_HIT;
        end else if (ent_s > req_q.port) begin
          verdict = VD_MISS;
        end
      end
      default: begin
        if ((req_q.port >= ent_s && {1'b0, req_q.port} < ent_l) ||
            (req_q.port <= ent_s && req_q.range_end > {1'b0, ent_s})) begin
          verdict = VD_CLASH;
        end
      end
    endcase
  end

  assign stat_o.verdict = verdict;
  assign stat_o.last  = (CW'(idx_q) + CW'(1)) == cnt_q;
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CW'(TableEntries));
  assign stat_o.vga   = (req_q.port >= VgaALo && req_q.range_end <= VgaAEnd) ||
                        (req_q.port >= VgaBLo && req_q.range_end <= VgaBEnd);
  assign stat_o.ins_shift = cnt_q > pos_q;
  assign stat_o.rem_shift = (pos_q + CW'(1)) < cnt_q;
  assign stat_o.sh_last   = is_rel ? ((CW'(src_q) + CW'(1)) == cnt_q)
                                   : (CW'(src_q) == pos_q);
  assign stat_o.cmd = req_q.command;

  // new entry for an insert
  assign any_lim   = cand_q[18:0] + {2'b0, req_q.size};
  assign new_s     = (req_q.command == CMD_ALLOC_AT) ? req_q.port : cand_q[17:0];
  assign new_l     = (req_q.command == CMD_ALLOC_AT) ? at_end : any_lim;
  assign grant_val = new_s;

  always_comb begin
    we    = 1'b0;
    waddr = IW'(pos_q);
    wdata = {new_s, new_l};
    if (ctl_i.init_wr) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {SentinelPort, SentinelLimit};
    end else if (ctl_i.sh_wr) begin
      we    = 1'b1;
      waddr = is_rel ? (src_q - IW'(1)) : (src_q + IW'(1));
      wdata = rdata;
    end else if (ctl_i.put) begin
      we = 1'b1;
    end
  end

  assign raddr = ctl_i.sh_rd ? src_q : idx_d;

  ipra_ram #(
    .Width (37),
    .Depth (TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
      cnt_q  <= CW'(1);
      idx_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      idx_q <= idx_d;
      if (ctl_i.put) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (ctl_i.dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    if (ctl_i.load) begin
      req_q  <= req_i;
      mask_q <= load_mask;
    end
    if (ctl_i.hit) begin
      pos_q <= CW'(idx_q);
    end else if (ctl_i.end_list) begin
      pos_q <= cnt_q;
    end
    if (ctl_i.sh_start) begin
      src_q <= is_rel ? IW'(pos_q + CW'(1)) : IW'(cnt_q - CW'(1));
    end else if (ctl_i.sh_wr) begin
      src_q <= is_rel ? (src_q + IW'(1)) : (src_q - IW'(1));
    end
    if (ctl_i.res_we) begin
      rsp_q.status       <= ctl_i.res_status;
      rsp_q.granted_port <= ctl_i.res_grant ? grant_val : 18'd0;
    end
  end

  assign rsp_o = rsp_q;

endmodule

FILE: design/ipra_ctrl.sv
// Allocator controller: sequences load, table walk, entry shifts and the
// result strobe. Depends on ipra_pkg.
`timescale 1ns / 1ps

module ipra_ctrl import ipra_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  output logic  done_o,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_FIRST, S_SCAN, S_ENDL, S_ACT, S_SH_RD, S_SH_WR, S_PUT, S_REMFIN
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.res_status = ST_OK;
    case (state_q)
      S_INIT: begin
        ctl_o.init_wr = 1'b1;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d = S_FIRST;
        end
      end
      S_FIRST: begin
        if (stat_i.cmd == CMD_CHECK && stat_i.vga) begin
          ctl_o.res_we = 1'b1;
          state_d = S_IDLE;
        end else if (stat_i.empty) begin
          state_d = S_ENDL;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        case (stat_i.verdict)
          VD_HIT: begin
            ctl_o.hit = 1'b1;
            state_d = S_ACT;
          end
          VD_CLASH: begin
            ctl_o.res_we = 1'b1;
            ctl_o.res_status = ST_CLASH;
            state_d = S_IDLE;
          end
          VD_MISS: begin
            ctl_o.res_we = 1'b1;
            ctl_o.res_status = ST_NOTFOUND;
            state_d = S_IDLE;
          end
          default: begin
            if (stat_i.last) begin
              state_d = S_ENDL;
            end else begin
              ctl_o.step = 1'b1;
            end
          end
        endcase
      end
      S_ENDL: begin
        case (stat_i.cmd)
          CMD_ALLOC_AT: begin
            ctl_o.end_list = 1'b1;
            state_d = S_ACT;
          end
          CMD_ALLOC_ANY: begin
            ctl_o.res_we = 1'b1;
            ctl_o.res_status = ST_NOSPACE;
            state_d = S_IDLE;
          end
          CMD_RELEASE: begin
            ctl_o.res_we = 1'b1;
            ctl_o.res_status = ST_NOTFOUND;
            state_d = S_IDLE;
          end
          default: begin
            ctl_o.res_we = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_ACT: begin
        if (stat_i.cmd == CMD_RELEASE) begin
          if (stat_i.rem_shift) begin
            ctl_o.sh_start = 1'b1;
            state_d = S_SH_RD;
          end else begin
            state_d = S_REMFIN;
          end
        end else if (stat_i.full) begin
          ctl_o.res_we = 1'b1;
          ctl_o.res_status = ST_FULL;
          state_d = S_IDLE;
        end else if (stat_i.ins_shift) begin
          ctl_o.sh_start = 1'b1;
          state_d = S_SH_RD;
        end else begin
          state_d = S_PUT;
        end
      end
      S_SH_RD: begin
        ctl_o.sh_rd = 1'b1;
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        ctl_o.sh_wr = 1'b1;
        if (!stat_i.sh_last) begin
          state_d = S_SH_RD;
        end else if (stat_i.cmd == CMD_RELEASE) begin
          state_d = S_REMFIN;
        end else begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        ctl_o.put = 1'b1;
        ctl_o.res_we = 1'b1;
        ctl_o.res_grant = 1'b1;
        state_d = S_IDLE;
      end
      S_REMFIN: begin
        ctl_o.dec = 1'b1;
        ctl_o.res_we = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ctl_o.res_we;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule
